[src/pip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and codes for the point-in-polygon test: request and result
// payloads, operation codes, controller states, command and status groups.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned FLD_W  = 16;
    localparam int unsigned HELD_W = 7;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [FLD_W-1:0] coord_x;
        logic signed [FLD_W-1:0] coord_y;
    } pip_in_t;

    typedef struct packed {
        logic              inside_res;
        logic              on_boundary;
        logic [HELD_W-1:0] vertices_held;
    } pip_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } pip_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_edge;
        logic query_start;
        logic out_load;
        logic out_take;
    } pip_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_full;
    } pip_status_t;

endpackage

[src/pip_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl
// Controller: request decode, vertex count, edge walk sequencing over the
// vertex memory and result hand-off.
// ----------------------------------------------------------------------------
module pip_ctrl
    import pip_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [OP_W-1:0]                      in_op,
    output logic                                 in_ready,
    input  logic                                 out_ready,
    input  pip_status_t                          status,
    output pip_cmd_t                             cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]      addr,
    output logic [$clog2(MAX_VERTICES+1)-1:0]    vertex_cnt
);

    localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
    localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);

    pip_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] last_idx;
    logic [CNT_W-1:0] k_prev;
    logic             accept;

    assign last_idx   = count_reg - CNT_W'(1);
    assign k_prev     = k_reg - CNT_W'(1);
    assign vertex_cnt = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        cmd        = '0;
        addr       = count_reg[ADDR_W-1:0];
        in_ready   = 1'b0;
        accept     = 1'b0;
        cmd.out_take = out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                accept   = in_valid;
                if (accept)
                begin
                    case (in_op)
                        OP_LOAD:
                        begin
                            if (count_reg != CNT_W'(MAX_VERTICES))
                            begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_QUERY:
                        begin
                            cmd.query_start = 1'b1;
                            k_next          = '0;
                            state_next      = (count_reg == '0) ? ST_DONE : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // first read fetches the last vertex, then vertices 0 .. n-1
                cmd.rd_en   = 1'b1;
                cmd.rd_edge = (k_reg != '0);
                addr        = (k_reg == '0) ? last_idx[ADDR_W-1:0] : k_prev[ADDR_W-1:0];
                k_next      = k_reg + CNT_W'(1);
                if (k_reg == count_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/pip_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex memory, query point, two-stage edge test (products, then cross and
// dot signs), crossing parity and the result register.
// ----------------------------------------------------------------------------
module pip_datapath
    import pip_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned COORD_BITS   = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pip_in_t                              in_data,
    input  pip_cmd_t                             cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]      addr,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]    vertex_cnt,
    output pip_status_t                          status,
    output logic                                 out_valid,
    output pip_out_t                             out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int unsigned CW    = (COORD_BITS < FLD_W) ? COORD_BITS : FLD_W;
    localparam int unsigned DW    = CW + 1;
    localparam int unsigned PW    = 2 * DW;
    localparam int unsigned SW    = PW + 1;

    logic signed [CW-1:0] mem_x [MAX_VERTICES];
    logic signed [CW-1:0] mem_y [MAX_VERTICES];

    logic signed [CW-1:0] in_x, in_y;
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [CW-1:0] rd_x_reg, rd_y_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic                 rd_vld_reg, rd_edge_reg;

    logic signed [DW-1:0] ux, uy, vx, vy;
    logic signed [PW-1:0] m_uxvy_reg, m_uyvx_reg, m_uxvx_reg, m_uyvy_reg;
    logic                 st1_vld_reg, st1_cross_reg, st1_dpos_reg;

    logic signed [SW-1:0] cr, dt;
    logic                 on_edge, left;
    logic                 edge_reg, parity_reg;

    logic                 out_valid_reg;
    pip_out_t             out_reg;
    logic [CNT_W+HELD_W-1:0] held_ext;

    assign in_x = in_data.coord_x[CW-1:0];
    assign in_y = in_data.coord_y[CW-1:0];

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_x[addr] <= in_x;
            mem_y[addr] <= in_y;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[addr];
            rd_y_reg <= mem_y[addr];
        end
    end

    // stage 1: offsets from the query point and their products
    assign ux = DW'(rd_x_reg) - DW'(px_reg);
    assign uy = DW'(rd_y_reg) - DW'(py_reg);
    assign vx = DW'(prev_x_reg) - DW'(px_reg);
    assign vy = DW'(prev_y_reg) - DW'(py_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg    <= rd_x_reg;
            prev_y_reg    <= rd_y_reg;
            m_uxvy_reg    <= ux * vy;
            m_uyvx_reg    <= uy * vx;
            m_uxvx_reg    <= ux * vx;
            m_uyvy_reg    <= uy * vy;
            st1_cross_reg <= (uy > 0) != (vy > 0);
            st1_dpos_reg  <= (uy > vy);
        end
    end

    // stage 2: cross product doubles as the crossing numerator
    assign cr      = SW'(m_uxvy_reg) - SW'(m_uyvx_reg);
    assign dt      = SW'(m_uxvx_reg) + SW'(m_uyvy_reg);
    assign on_edge = (cr == '0) && (dt <= 0);
    assign left    = st1_dpos_reg ? (cr < 0) : (cr > 0);

    assign held_ext = {{HELD_W{1'b0}}, vertex_cnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg    <= 1'b0;
            rd_edge_reg   <= 1'b0;
            st1_vld_reg   <= 1'b0;
            edge_reg      <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= cmd.rd_en;
            rd_edge_reg <= cmd.rd_edge;
            st1_vld_reg <= rd_vld_reg && rd_edge_reg;
            if (cmd.query_start)
            begin
                edge_reg   <= 1'b0;
                parity_reg <= 1'b0;
            end
            else if (st1_vld_reg)
            begin
                edge_reg <= edge_reg | on_edge;
                if (st1_cross_reg && left)
                    parity_reg <= ~parity_reg;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (cmd.out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.inside_res    <= edge_reg | parity_reg;
            out_reg.on_boundary   <= edge_reg;
            out_reg.vertices_held <= held_ext[HELD_W-1:0];
        end
    end

    assign status.pipe_busy = rd_vld_reg | st1_vld_reg;
    assign status.out_full  = out_valid_reg;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

endmodule

[src/point_in_polygon_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Ray-casting point-in-polygon test over a vertex memory filled by load
// requests and emptied by clear requests.
//
//   channel  direction  payload    handshake
//   in       input      pip_in_t   in_valid / in_ready
//   out      output     pip_out_t  out_valid / out_ready
//
// load, clear and unused codes are handled in the idle state and do not leave it
// a query over n > 0 vertices is accepted, makes n + 1 memory reads, drains
//   the pipeline and then loads the result
// a query on an empty store skips the reads and goes straight to the result load
// reset empties the vertex count at once; memory contents are not cleared
// a held result stalls only the end of the next query, not loads or clears
// ----------------------------------------------------------------------------
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned COORD_BITS   = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pip_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pip_out_t out_data
);

    localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
    localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);

    pip_cmd_t          cmd;
    pip_status_t       status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  vertex_cnt;

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_op      (in_data.op),
        .in_ready   (in_ready),
        .out_ready  (out_ready),
        .status     (status),
        .cmd        (cmd),
        .addr       (addr),
        .vertex_cnt (vertex_cnt)
    );

    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .cmd        (cmd),
        .addr       (addr),
        .vertex_cnt (vertex_cnt),
        .status     (status),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

[src/pip_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks for the point-in-polygon test, bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker
    import pip_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input pip_in_t  in_data,
    input logic     out_valid,
    input logic     out_ready,
    input pip_out_t out_data
);

    // a boundary hit always counts as inside
    a_boundary_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.on_boundary ? out_data.inside_res : 1'b1))
        else $error("on_boundary without inside_res");

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // a query blocks further requests while the edges are walked
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.op == OP_QUERY) |=> !in_ready)
        else $error("request accepted during a query");

    // a new result appears only at the end of a query
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a query in progress");

    // loads and clears never produce a result
    a_no_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.op != OP_QUERY) |=> !$rose(out_valid))
        else $error("result after a non-query request");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
